// ===== hdl/can_frame_receive_queue_top_macros.svh =====
// assertion macros for the receive queue, used by can_rxq_ctrl
// expects clk and rst_n in the scope of use
`ifndef CAN_FRAME_RECEIVE_QUEUE_TOP_MACROS_SVH
`define CAN_FRAME_RECEIVE_QUEUE_TOP_MACROS_SVH

// same-cycle implication
`define CRQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/can_rxq_pkg.sv =====
// types and constants for the can frame receive queue
// no dependencies
`default_nettype none

package can_rxq_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int ID_W          = 29;
    localparam int DATA_W        = 64;
    localparam int LEN_W         = 4;
    localparam int DROP_W        = 8;
    localparam int HW_OUT_W      = 4;

    localparam logic [LEN_W-1:0]    REQ_LEN  = 4'd8;
    localparam logic [DROP_W-1:0]   DROP_MAX = 8'hFF;
    localparam logic [HW_OUT_W-1:0] HW_MAX   = 4'd15;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef enum logic [2:0] {
        ST_STORED   = 3'd0,
        ST_REJECTED = 3'd1,
        ST_FULL     = 3'd2,
        ST_POPPED   = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    typedef struct packed {
        status_t               status;
        logic [ID_W-1:0]       id;
        logic [DATA_W-1:0]     data;
        logic [DROP_W-1:0]     drop_count;
        logic [HW_OUT_W-1:0]   high_water;
    } result_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/can_rxq_mem.sv =====
// frame slot storage: one write port, one registered read port
// depends on can_rxq_pkg
`default_nettype none

module can_rxq_mem #(
    parameter int SLOTS = can_rxq_pkg::SLOTS_DEFAULT,
    parameter int PTR_W = $clog2(SLOTS)
) (
    input  wire logic                          clk,
    input  wire can_rxq_pkg::mem_ctl_t         ctl,
    input  wire logic [PTR_W-1:0]              wr_addr,
    input  wire logic [can_rxq_pkg::ID_W-1:0]  wr_id,
    input  wire logic [can_rxq_pkg::DATA_W-1:0] wr_data,
    input  wire logic [PTR_W-1:0]              rd_addr,
    output logic      [can_rxq_pkg::ID_W-1:0]  rd_id,
    output logic      [can_rxq_pkg::DATA_W-1:0] rd_data
);

    logic [can_rxq_pkg::ID_W-1:0]   id_mem   [SLOTS];
    logic [can_rxq_pkg::DATA_W-1:0] data_mem [SLOTS];
    logic [can_rxq_pkg::ID_W-1:0]   rd_id_reg;
    logic [can_rxq_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            id_mem[wr_addr]   <= wr_id;
            data_mem[wr_addr] <= wr_data;
        end
    end

    // read data only moves on a pop, so it holds while the result waits
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_id_reg   <= id_mem[rd_addr];
            rd_data_reg <= data_mem[rd_addr];
        end
    end

    assign rd_id   = rd_id_reg;
    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hdl/can_rxq_ctrl.sv =====
// queue control: filter, pointers, drop counter, high-water mark, result register
// depends on can_rxq_pkg and the assertion macro header
`default_nettype none
`include "can_frame_receive_queue_top_macros.svh"

module can_rxq_ctrl #(
    parameter int SLOTS = can_rxq_pkg::SLOTS_DEFAULT,
    parameter int PTR_W = $clog2(SLOTS)
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             item_valid,
    output logic                                  item_ready,
    input  wire logic                             action,
    input  wire logic [can_rxq_pkg::LEN_W-1:0]    frame_length,
    input  wire logic                             is_extended,
    input  wire logic                             is_remote,
    output can_rxq_pkg::mem_ctl_t                 mem_ctl,
    output logic      [PTR_W-1:0]                 wr_ptr,
    output logic      [PTR_W-1:0]                 rd_ptr,
    input  wire logic [can_rxq_pkg::ID_W-1:0]     rd_id,
    input  wire logic [can_rxq_pkg::DATA_W-1:0]   rd_data,
    output logic                                  res_valid,
    input  wire logic                             res_ready,
    output can_rxq_pkg::result_t                  res
);

    localparam int OCC_W = PTR_W + 1;
    localparam int HW_W  = (PTR_W > can_rxq_pkg::HW_OUT_W) ? PTR_W : can_rxq_pkg::HW_OUT_W;

    logic [PTR_W-1:0]                  wp_reg, wp_next;
    logic [PTR_W-1:0]                  rp_reg, rp_next;
    logic [can_rxq_pkg::DROP_W-1:0]    drop_reg, drop_next;
    logic [PTR_W-1:0]                  peak_reg, peak_next;
    logic                              valid_reg, valid_next;
    can_rxq_pkg::status_t              status_reg, status_next;
    logic [can_rxq_pkg::HW_OUT_W-1:0]  hw_reg, hw_next;

    logic             item_fire;
    logic             filter_ok;
    logic             is_full;
    logic             is_empty;
    logic [PTR_W-1:0] wp_adv;
    logic [PTR_W-1:0] rp_adv;
    logic [OCC_W-1:0] used_wide;
    logic [PTR_W-1:0] used;
    logic [HW_W-1:0]  peak_ext;

    assign item_ready = !valid_reg || res_ready;
    assign item_fire  = item_valid && item_ready;

    assign filter_ok = (frame_length == can_rxq_pkg::REQ_LEN) && is_extended && !is_remote;
    assign wp_adv    = (wp_reg == PTR_W'(SLOTS - 1)) ? '0 : wp_reg + 1'b1;
    assign rp_adv    = (rp_reg == PTR_W'(SLOTS - 1)) ? '0 : rp_reg + 1'b1;
    assign is_full   = (wp_adv == rp_reg);
    assign is_empty  = (rp_reg == wp_reg);

    // occupancy after a store, wrapping for any slot count
    assign used_wide = ({1'b0, wp_adv} >= {1'b0, rp_reg})
                     ? ({1'b0, wp_adv} - {1'b0, rp_reg})
                     : ({1'b0, wp_adv} + OCC_W'(SLOTS) - {1'b0, rp_reg});
    assign used      = used_wide[PTR_W-1:0];

    always_comb
    begin
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        drop_next   = drop_reg;
        peak_next   = peak_reg;
        status_next = status_reg;
        mem_ctl     = '0;
        if (item_fire)
        begin
            if (action == can_rxq_pkg::ACT_PUSH)
            begin
                if (!filter_ok)
                begin
                    status_next = can_rxq_pkg::ST_REJECTED;
                end
                else if (is_full)
                begin
                    status_next = can_rxq_pkg::ST_FULL;
                    if (drop_reg != can_rxq_pkg::DROP_MAX)
                    begin
                        drop_next = drop_reg + 1'b1;
                    end
                end
                else
                begin
                    status_next   = can_rxq_pkg::ST_STORED;
                    mem_ctl.wr_en = 1'b1;
                    wp_next       = wp_adv;
                    if (used > peak_reg)
                    begin
                        peak_next = used;
                    end
                end
            end
            else
            begin
                if (is_empty)
                begin
                    status_next = can_rxq_pkg::ST_EMPTY;
                end
                else
                begin
                    status_next   = can_rxq_pkg::ST_POPPED;
                    mem_ctl.rd_en = 1'b1;
                    rp_next       = rp_adv;
                end
            end
        end
    end

    // high-water output saturates at what four bits can show
    assign peak_ext = HW_W'(peak_next);
    assign hw_next  = (peak_ext > HW_W'(can_rxq_pkg::HW_MAX))
                    ? can_rxq_pkg::HW_MAX : peak_ext[can_rxq_pkg::HW_OUT_W-1:0];

    assign valid_next = item_fire ? 1'b1 : (res_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= '0;
            rp_reg     <= '0;
            drop_reg   <= '0;
            peak_reg   <= '0;
            valid_reg  <= 1'b0;
            status_reg <= can_rxq_pkg::ST_STORED;
            hw_reg     <= '0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            drop_reg  <= drop_next;
            peak_reg  <= peak_next;
            valid_reg <= valid_next;
            if (item_fire)
            begin
                status_reg <= status_next;
                hw_reg     <= hw_next;
            end
        end
    end

    assign wr_ptr    = wp_reg;
    assign rd_ptr    = rp_reg;
    assign res_valid = valid_reg;

    always_comb
    begin
        res            = '0;
        res.status     = status_reg;
        res.drop_count = drop_reg;
        res.high_water = hw_reg;
        if (status_reg == can_rxq_pkg::ST_POPPED)
        begin
            res.id   = rd_id;
            res.data = rd_data;
        end
    end

    `CRQ_ASSERT_NEXT(a_drop_monotonic, 1'b1, drop_reg >= $past(drop_reg), "drop count went down")
    `CRQ_ASSERT_NEXT(a_peak_monotonic, 1'b1, peak_reg >= $past(peak_reg), "high-water went down")
    `CRQ_ASSERT_NEXT(a_pop_advances, item_fire && action && !is_empty, rp_reg != $past(rp_reg), "pop left read pointer")
    `CRQ_ASSERT_NEXT(a_full_holds_wp, item_fire && !action && filter_ok && is_full, wp_reg == $past(wp_reg), "drop moved write pointer")
    `CRQ_ASSERT_NOW(a_ptr_range, 1'b1, (wp_reg <= PTR_W'(SLOTS - 1)) && (rp_reg <= PTR_W'(SLOTS - 1)), "pointer out of range")

endmodule

`default_nettype wire

// ===== hdl/can_rxq_out_buf.sv =====
// two-entry output buffer between the result register and the result channel
// depends on can_rxq_pkg
`default_nettype none

module can_rxq_out_buf (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire can_rxq_pkg::result_t  in_beat,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output can_rxq_pkg::result_t       out_beat
);

    logic [1:0]           count_reg, count_next;
    can_rxq_pkg::result_t e0_reg, e1_reg;
    logic                 push;
    logic                 pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // head always in e0; push and pop together only happen with one beat held
    always_ff @(posedge clk)
    begin
        if (push && pop)
        begin
            e0_reg <= in_beat;
        end
        else if (pop)
        begin
            e0_reg <= e1_reg;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                e0_reg <= in_beat;
            end
            else
            begin
                e1_reg <= in_beat;
            end
        end
    end

    assign out_beat = e0_reg;

endmodule

`default_nettype wire

// ===== hdl/can_frame_receive_queue_top.sv =====
// can frame receive queue: top level
// instantiates can_rxq_ctrl, can_rxq_mem and can_rxq_out_buf; uses can_rxq_pkg
//
// input channel item_valid/item_ready carries one action beat: a push that
// offers a frame (action 0) or a pop of the oldest frame (action 1). a push
// is stored only if frame_length is 8, is_extended is set and is_remote is
// clear; otherwise status is "rejected". with the ring full (SLOTS-1 frames)
// the push is dropped and drop_count rises, saturating at 255.
// result channel result_valid/result_ready returns one beat per action with
// status, popped frame (zero otherwise), drop_count and high_water.
// an accepted action passes the result register and then the output buffer
// before result_valid rises. throughput is one beat per cycle while
// item_ready is high; the filter, pointer compare and slot memory write/read
// all complete in the accepting cycle, the slot read landing in a register.
// if the receiver stalls, up to three results are held (result register plus
// two-entry output buffer) before item_ready drops.
// reset clears pointers, counters and valid flags at once; slot contents are
// not cleared and are only read after being written.
`default_nettype none

module can_frame_receive_queue_top #(
    parameter int SLOTS = can_rxq_pkg::SLOTS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            item_valid,
    output logic                                 item_ready,
    input  wire logic                            action,
    input  wire logic [can_rxq_pkg::LEN_W-1:0]   frame_length,
    input  wire logic                            is_extended,
    input  wire logic                            is_remote,
    input  wire logic [can_rxq_pkg::ID_W-1:0]    frame_id,
    input  wire logic [can_rxq_pkg::DATA_W-1:0]  frame_data,
    output logic                                 result_valid,
    input  wire logic                            result_ready,
    output logic      [2:0]                      status,
    output logic      [can_rxq_pkg::ID_W-1:0]    out_id,
    output logic      [can_rxq_pkg::DATA_W-1:0]  out_data,
    output logic      [can_rxq_pkg::DROP_W-1:0]  drop_count,
    output logic      [can_rxq_pkg::HW_OUT_W-1:0] high_water
);

    localparam int PTR_W = $clog2(SLOTS);

    can_rxq_pkg::mem_ctl_t          mem_ctl;
    logic [PTR_W-1:0]               wr_ptr;
    logic [PTR_W-1:0]               rd_ptr;
    logic [can_rxq_pkg::ID_W-1:0]   rd_id;
    logic [can_rxq_pkg::DATA_W-1:0] rd_data;
    logic                           res_valid;
    logic                           res_ready;
    can_rxq_pkg::result_t           res;
    can_rxq_pkg::result_t           out_beat;

    can_rxq_ctrl #(
        .SLOTS (SLOTS),
        .PTR_W (PTR_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .action       (action),
        .frame_length (frame_length),
        .is_extended  (is_extended),
        .is_remote    (is_remote),
        .mem_ctl      (mem_ctl),
        .wr_ptr       (wr_ptr),
        .rd_ptr       (rd_ptr),
        .rd_id        (rd_id),
        .rd_data      (rd_data),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    can_rxq_mem #(
        .SLOTS (SLOTS),
        .PTR_W (PTR_W)
    ) u_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (wr_ptr),
        .wr_id   (frame_id),
        .wr_data (frame_data),
        .rd_addr (rd_ptr),
        .rd_id   (rd_id),
        .rd_data (rd_data)
    );

    can_rxq_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_beat   (res),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_beat  (out_beat)
    );

    assign status     = out_beat.status;
    assign out_id     = out_beat.id;
    assign out_data   = out_beat.data;
    assign drop_count = out_beat.drop_count;
    assign high_water = out_beat.high_water;

endmodule

`default_nettype wire

// ===== tb/can_rxq_checker.sv =====
// result checker for the can frame receive queue: keeps its own copy of the ring,
// predicts each result beat and compares it against the dut output
// depends on can_rxq_pkg
`timescale 1ns / 100ps

module can_rxq_checker
    import can_rxq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_ready,
    input  logic                action,
    input  logic [LEN_W-1:0]    frame_length,
    input  logic                is_extended,
    input  logic                is_remote,
    input  logic [ID_W-1:0]     frame_id,
    input  logic [DATA_W-1:0]   frame_data,
    input  logic                result_valid,
    input  logic                result_ready,
    input  logic [2:0]          status,
    input  logic [ID_W-1:0]     out_id,
    input  logic [DATA_W-1:0]   out_data,
    input  logic [DROP_W-1:0]   drop_count,
    input  logic [HW_OUT_W-1:0] high_water,
    output int                  fail_count,
    output int                  outstanding,
    output int                  checked_count,
    output int                  full_count
);

    localparam int SLOTS = SLOTS_DEFAULT;

    logic [ID_W-1:0]   ring_id   [SLOTS];
    logic [DATA_W-1:0] ring_data [SLOTS];
    int unsigned       wr_ptr    = 0;
    int unsigned       rd_ptr    = 0;
    int unsigned       drops     = 0;
    int unsigned       peak      = 0;

    result_t awaited_outcomes[$];
    int      fails    = 0;
    int      waiting  = 0;
    int      compared = 0;
    int      fulls    = 0;

    assign fail_count    = fails;
    assign outstanding   = waiting;
    assign checked_count = compared;
    assign full_count    = fulls;

    // updates the shadow ring for one action and returns the result it causes
    function automatic result_t apply_queue_action(
        logic              act,
        logic [LEN_W-1:0]  len,
        logic              ext,
        logic              rtr,
        logic [ID_W-1:0]   id,
        logic [DATA_W-1:0] data
    );
        result_t     r;
        int unsigned nxt;
        int unsigned used;
        r = '0;
        if (act == ACT_PUSH)
        begin
            // filter is checked before fullness
            if (len != REQ_LEN || !ext || rtr)
            begin
                r.status = ST_REJECTED;
            end
            else
            begin
                nxt = (wr_ptr + 1) % SLOTS;
                if (nxt == rd_ptr)
                begin
                    if (drops < DROP_MAX)
                        drops++;
                    r.status = ST_FULL;
                end
                else
                begin
                    ring_id[wr_ptr]   = id;
                    ring_data[wr_ptr] = data;
                    wr_ptr            = nxt;
                    used              = (nxt + SLOTS - rd_ptr) % SLOTS;
                    if (used > peak)
                        peak = used;
                    r.status = ST_STORED;
                end
            end
        end
        else if (rd_ptr == wr_ptr)
        begin
            r.status = ST_EMPTY;
        end
        else
        begin
            r.id     = ring_id[rd_ptr];
            r.data   = ring_data[rd_ptr];
            rd_ptr   = (rd_ptr + 1) % SLOTS;
            r.status = ST_POPPED;
        end
        r.drop_count = drops[DROP_W-1:0];
        r.high_water = (peak > HW_MAX) ? HW_MAX : peak[HW_OUT_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            wr_ptr = 0;
            rd_ptr = 0;
            drops  = 0;
            peak   = 0;
            awaited_outcomes.delete();
            waiting = 0;
        end
        else
        begin
            // a result beat always belongs to an earlier action beat
            if (result_valid && result_ready)
            begin
                if (awaited_outcomes.size() == 0)
                begin
                    $error("result beat with nothing outstanding: status %0d id %h data %h",
                           status, out_id, out_data);
                    fails++;
                end
                else
                begin
                    want = awaited_outcomes.pop_front();
                    compared++;
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fails++;
                    end
                    if (out_id !== want.id)
                    begin
                        $error("out_id: expected %h, got %h", want.id, out_id);
                        fails++;
                    end
                    if (out_data !== want.data)
                    begin
                        $error("out_data: expected %h, got %h", want.data, out_data);
                        fails++;
                    end
                    if (drop_count !== want.drop_count)
                    begin
                        $error("drop_count: expected %0d, got %0d", want.drop_count,
                               drop_count);
                        fails++;
                    end
                    if (high_water !== want.high_water)
                    begin
                        $error("high_water: expected %0d, got %0d", want.high_water,
                               high_water);
                        fails++;
                    end
                end
            end
            if (item_valid && item_ready)
            begin
                want = apply_queue_action(action, frame_length, is_extended, is_remote,
                                          frame_id, frame_data);
                if (want.status == ST_FULL)
                    fulls++;
                awaited_outcomes.push_back(want);
            end
            waiting = awaited_outcomes.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// top of the can frame receive queue testbench: clock, reset, action beats and
// receiver stalls; checking is done by can_rxq_checker
// depends on can_rxq_pkg, can_rxq_checker and can_frame_receive_queue_top
`timescale 1ns / 100ps

module testbench;

    import can_rxq_pkg::*;

    localparam int HOLD_CYCLES    = 48;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_ready;
    logic                action       = ACT_PUSH;
    logic [LEN_W-1:0]    frame_length = '0;
    logic                is_extended  = 1'b0;
    logic                is_remote    = 1'b0;
    logic [ID_W-1:0]     frame_id     = '0;
    logic [DATA_W-1:0]   frame_data   = '0;
    logic                result_valid;
    logic                result_ready = 1'b1;
    logic [2:0]          status;
    logic [ID_W-1:0]     out_id;
    logic [DATA_W-1:0]   out_data;
    logic [DROP_W-1:0]   drop_count;
    logic [HW_OUT_W-1:0] high_water;

    int fail_count;
    int outstanding;
    int checked_count;
    int full_count;

    int gap_pct       = 0;
    int stall_pct     = 0;
    bit hold_off_req  = 1'b0;
    int beats_sent    = 0;
    int quiet_cycles  = 0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    can_frame_receive_queue_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .action       (action),
        .frame_length (frame_length),
        .is_extended  (is_extended),
        .is_remote    (is_remote),
        .frame_id     (frame_id),
        .frame_data   (frame_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .out_id       (out_id),
        .out_data     (out_data),
        .drop_count   (drop_count),
        .high_water   (high_water)
    );

    can_rxq_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .action        (action),
        .frame_length  (frame_length),
        .is_extended   (is_extended),
        .is_remote     (is_remote),
        .frame_id      (frame_id),
        .frame_data    (frame_data),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .status        (status),
        .out_id        (out_id),
        .out_data      (out_data),
        .drop_count    (drop_count),
        .high_water    (high_water),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .checked_count (checked_count),
        .full_count    (full_count)
    );

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    @(negedge clk);
                    result_ready <= 1'b0;
                end
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                repeat ($urandom_range(1, 5))
                begin
                    @(negedge clk);
                    result_ready <= 1'b0;
                end
            end
            else
            begin
                @(negedge clk);
                result_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic offer_beat(
        logic              act,
        logic [LEN_W-1:0]  len,
        logic              ext,
        logic              rtr,
        logic [ID_W-1:0]   id,
        logic [DATA_W-1:0] data
    );
        @(negedge clk);
        item_valid   <= 1'b1;
        action       <= act;
        frame_length <= len;
        is_extended  <= ext;
        is_remote    <= rtr;
        frame_id     <= id;
        frame_data   <= data;
        do
            @(posedge clk);
        while (!item_ready);
        beats_sent++;
    endtask

    task automatic sender_gap();
        if ($urandom_range(0, 99) < gap_pct)
        begin
            repeat ($urandom_range(1, 5))
            begin
                @(negedge clk);
                item_valid <= 1'b0;
            end
        end
    endtask

    // junk_pct of pushes carry a random length/extended/remote pattern
    task automatic offer_random(int pop_pct, int junk_pct);
        logic             act;
        logic [LEN_W-1:0] len;
        logic             ext;
        logic             rtr;
        sender_gap();
        act = ($urandom_range(0, 99) < pop_pct) ? ACT_POP : ACT_PUSH;
        if (act == ACT_PUSH && $urandom_range(0, 99) >= junk_pct)
        begin
            len = REQ_LEN;
            ext = 1'b1;
            rtr = 1'b0;
        end
        else
        begin
            len = LEN_W'($urandom_range(0, 15));
            ext = 1'($urandom_range(0, 1));
            rtr = 1'($urandom_range(0, 1));
        end
        offer_beat(act, len, ext, rtr, ID_W'($urandom), {$urandom, $urandom});
    endtask

    task automatic wait_drained();
        @(negedge clk);
        item_valid <= 1'b0;
        wait (outstanding == 0);
    endtask

    initial
    begin
        logic [ID_W-1:0]   id_pick;
        logic [DATA_W-1:0] data_pick;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty pop, each filter reject, fill to full, full plus filter
        offer_beat(ACT_POP, '0, 1'b0, 1'b0, '0, '0);
        offer_beat(ACT_PUSH, 4'd0, 1'b1, 1'b0, '1, '1);
        offer_beat(ACT_PUSH, 4'd15, 1'b1, 1'b0, '1, '1);
        offer_beat(ACT_PUSH, 4'd7, 1'b1, 1'b0, 29'h0ABCDEF1, 64'h0123456789ABCDEF);
        offer_beat(ACT_PUSH, 4'd9, 1'b1, 1'b0, 29'h0ABCDEF1, 64'h0123456789ABCDEF);
        offer_beat(ACT_PUSH, REQ_LEN, 1'b0, 1'b0, 29'h00000123, 64'hFEDCBA9876543210);
        offer_beat(ACT_PUSH, REQ_LEN, 1'b1, 1'b1, 29'h1FFFFFFE, 64'h8000000000000001);
        for (int i = 0; i < SLOTS_DEFAULT; i++)
        begin
            case (i)
                0:       begin id_pick = '1;           data_pick = '1; end
                1:       begin id_pick = '0;           data_pick = '0; end
                2:       begin id_pick = 29'h0AAAAAAA; data_pick = 64'h5555555555555555; end
                3:       begin id_pick = 29'h15555555; data_pick = 64'hAAAAAAAAAAAAAAAA; end
                default: begin id_pick = ID_W'($urandom); data_pick = {$urandom, $urandom}; end
            endcase
            // the last one lands on a full ring
            offer_beat(ACT_PUSH, REQ_LEN, 1'b1, 1'b0, id_pick, data_pick);
        end
        offer_beat(ACT_PUSH, REQ_LEN, 1'b1, 1'b1, '1, '1);
        wait_drained();

        gap_pct   = 20;
        stall_pct = 20;
        repeat (100) offer_random(45, 20);

        // long receiver hold-off while beats keep coming, so the input backs up
        gap_pct      = 0;
        hold_off_req = 1'b1;
        repeat (60) offer_random(30, 10);
        gap_pct = 20;
        repeat (140) offer_random(45, 20);

        // flood of pushes drives the drop counter into saturation
        gap_pct   = 10;
        stall_pct = 30;
        repeat (350) offer_random(5, 5);
        wait_drained();

        gap_pct   = 30;
        stall_pct = 10;
        repeat (250) offer_random(65, 25);

        gap_pct   = 0;
        stall_pct = 0;
        repeat (100) offer_random(50, 20);

        gap_pct   = 15;
        stall_pct = 15;
        repeat (200) offer_random(40, 20);

        gap_pct   = 0;
        stall_pct = 0;
        repeat (150) offer_random(50, 20);

        wait_drained();
        repeat (10) @(posedge clk);

        $display("%0d action beats driven, %0d result beats compared, %0d pushes met a full ring",
                 beats_sent, checked_count, full_count);
        $display("last drop_count %0d, last high_water %0d", drop_count, high_water);
        if (fail_count == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
